### rtl/srs_pkg.sv
// srs_pkg: shared types and constants for the signed radix sorter
// item and result payload structs, cell control struct, controller states
// depends on nothing
`timescale 1ns / 1ps
package srs_pkg;

  // fixed field width of the value on both channels
  localparam int FIELD_W = 64;

  // default batch capacity and stored value width
  localparam int DEF_MAX_ITEMS   = 64;
  localparam int DEF_VALUE_WIDTH = 64;

  // one input item
  typedef struct packed {
    logic signed [FIELD_W-1:0] value;
    logic                      last;
  } srs_in_t;

  // one result item
  typedef struct packed {
    logic signed [FIELD_W-1:0] value_res;
    logic                      last_res;
    logic                      dropped;
  } srs_out_t;

  // what the row of cells does this cycle
  typedef struct packed {
    logic ins;    // insert the broadcast value in order
    logic drain;  // shift every cell one place toward the head
  } srs_ctl_t;

  // controller states
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } srs_state_t;

endpackage

### rtl/srs_cell.sv
// srs_cell: one slot of the sorting row
// holds one value in ascending order, takes from its left or right neighbor
// depends on srs_pkg
`timescale 1ns / 1ps
module srs_cell #(
  parameter int VALUE_WIDTH = srs_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  srs_pkg::srs_ctl_t             ctl,
  input  logic signed [VALUE_WIDTH-1:0] ins_value,
  input  logic                          prev_take,
  input  logic signed [VALUE_WIDTH-1:0] prev_value,
  input  logic                          prev_valid,
  input  logic signed [VALUE_WIDTH-1:0] next_value,
  input  logic                          next_valid,
  output logic                          take,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          valid
);
  import srs_pkg::*;

  // new value goes at or before this slot
  assign take = !valid || (ins_value < value);

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.drain) begin
      valid <= next_valid;
    end else if (ctl.ins && take) begin
      valid <= prev_take ? prev_valid : 1'b1;
    end
  end

  // stored value
  always_ff @(posedge clk) begin
    if (ctl.drain) begin
      value <= next_value;
    end else if (ctl.ins && take) begin
      value <= prev_take ? prev_value : ins_value;
    end
  end

endmodule

### rtl/signed_binary_msd_radix_sorter.sv
// signed_binary_msd_radix_sorter: batch sorter in ascending signed order
// controller plus a row of srs_cell slots kept in order as items arrive
// depends on srs_pkg, srs_cell
//
//   channel | signals                      | moves
//   --------+------------------------------+-------------------------------
//   input   | item_valid, item_ready, item | one value, last ends the batch
//   output  | res_valid, res_ready, res    | sorted values, head first
//
// each value is inserted in order into the cell row in the cycle it is
// accepted while there is room, so no separate sort phase runs. the
// stored values then drain one result per cycle while res_ready is high,
// from the head cell register. items are refused while a batch drains.
// reset clears the cell occupancy, the count and the overflow flag.
// a stalled result holds in the head cell until it is taken.
`timescale 1ns / 1ps
module signed_binary_msd_radix_sorter #(
  parameter int MAX_ITEMS   = srs_pkg::DEF_MAX_ITEMS,
  parameter int VALUE_WIDTH = srs_pkg::DEF_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  srs_pkg::srs_in_t  item,
  output logic              res_valid,
  input  logic              res_ready,
  output srs_pkg::srs_out_t res
);
  import srs_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  srs_state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic             overflow;

  logic item_acc, res_acc, full, res_last;
  srs_ctl_t ctl;

  logic signed [VALUE_WIDTH-1:0] ins_value;
  logic signed [VALUE_WIDTH-1:0] cell_value [MAX_ITEMS];
  logic                          cell_valid [MAX_ITEMS];
  logic                          cell_take  [MAX_ITEMS];

  assign item_acc  = item_valid && item_ready;
  assign res_acc   = res_valid && res_ready;
  assign full      = (count == CNT_W'(MAX_ITEMS));
  assign res_last  = (count == CNT_W'(1));
  assign ins_value = item.value[VALUE_WIDTH-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:  if (item_acc && item.last) state_next = ST_DRAIN;
      ST_DRAIN: if (res_acc && res_last) state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // controller outputs
  always_comb begin
    item_ready = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      ST_LOAD:  item_ready = 1'b1;
      ST_DRAIN: res_valid  = 1'b1;
      default:  item_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // row control: insert only while there is room
  assign ctl.ins   = item_acc && !full;
  assign ctl.drain = res_acc;

  // item count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (res_acc) begin
      count <= count - CNT_W'(1);
      if (res_last) overflow <= 1'b0;
    end else if (item_acc) begin
      if (full) overflow <= 1'b1;
      else      count    <= count + CNT_W'(1);
    end
  end

  // row of cells, head at index 0
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                          p_take, p_valid, n_valid;
    logic signed [VALUE_WIDTH-1:0] p_value, n_value;

    if (i == 0) begin : g_head
      assign p_take  = 1'b0;
      assign p_valid = 1'b0;
      assign p_value = '0;
    end else begin : g_body
      assign p_take  = cell_take[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_value = cell_value[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_value = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_value = cell_value[i+1];
    end

    srs_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .ins_value  (ins_value),
      .prev_take  (p_take),
      .prev_value (p_value),
      .prev_valid (p_valid),
      .next_value (n_value),
      .next_valid (n_valid),
      .take       (cell_take[i]),
      .value      (cell_value[i]),
      .valid      (cell_valid[i])
    );
  end

  // result from the head cell, sign-extended
  assign res.value_res = FIELD_W'(cell_value[0]);
  assign res.last_res  = res_last;
  assign res.dropped   = res_last && overflow;

endmodule

### rtl/srs_checker.sv
// srs_checker: port-level checks for the signed radix sorter
// bound to the top level below
// depends on srs_pkg
`timescale 1ns / 1ps
module srs_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input srs_pkg::srs_in_t  item,
  input logic              res_valid,
  input logic              res_ready,
  input srs_pkg::srs_out_t res
);
  import srs_pkg::*;

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // never loading and draining at once
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && res_valid))
    else $error("input taken while results pending");

  // the batch-closing item starts the drain
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.last |=> res_valid)
    else $error("no result after last item");

  // the final result returns the block to loading
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last_res |=> !res_valid && item_ready)
    else $error("block not reloading after final result");

  // drop flag only on the final result
  a_drop_final: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last_res |-> !res.dropped)
    else $error("drop flag on a non-final result");

endmodule

bind signed_binary_msd_radix_sorter srs_checker u_srs_checker (.*);
